/* rtl/serial_can_frame_mailbox_unit_defines.svh */
// Assertion macros for the serial frame mailbox; clock clk, reset arst_n.
`ifndef SERIAL_CAN_FRAME_MAILBOX_UNIT_DEFINES_SVH
`define SERIAL_CAN_FRAME_MAILBOX_UNIT_DEFINES_SVH

// Same-cycle implication
`define SCFM_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SCFM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/scfm_pkg.sv */
// Shared constants, codes and types of the serial frame mailbox.
`timescale 1ns / 1ps
package scfm_pkg;

	// Field widths
	localparam int BYTE_W = 8;
	localparam int ID_W = 8;
	localparam int LEN_W = 4;
	localparam int DATA_BYTES = 8;
	localparam int DATA_W = DATA_BYTES * BYTE_W;
	localparam int GAP_LIMIT_W = 16;
	localparam int GAP_COUNT_BITS_DEF = 16;

	// Frame layout: id, length, data bytes, checksum
	localparam int FRAME_HDR = 2;
	localparam int FRAME_LEN = 11;
	localparam int STORED_BYTES = FRAME_LEN - 1;
	localparam int MAX_DATA_LEN = 8;
	localparam int CNT_W = $clog2(FRAME_LEN);

	// Mailbox and result queue
	localparam int MB_DEPTH = 256;
	localparam int MB_AW = $clog2(MB_DEPTH);
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);
	localparam int Q_CW = Q_AW + 1;

	// Register port
	localparam int APB_DW = 32;
	localparam int REG_SEL_BIT = 2;
	localparam int APB_AW = REG_SEL_BIT + 1;

	// Command codes
	localparam logic [1:0] CMD_BYTE = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_READ = 2'd0;
	localparam logic [1:0] ST_STORED = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;

	// Register indexes
	localparam logic REG_RX_ENABLE = 1'b0;
	localparam logic REG_GAP_LIMIT = 1'b1;

	// Completed frame from the assembler
	typedef struct packed {
		logic              done;
		logic              drop;
		logic [ID_W-1:0]   id;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] data;
	} frame_evt_t;

	// One result word
	typedef struct packed {
		logic [1:0]        status;
		logic [ID_W-1:0]   id;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] data;
	} result_t;

endpackage

/* rtl/serial_can_frame_mailbox_unit.sv */
// A result word passes the stage-1 register and then the result queue before it is offered.
// Throughput: one input word per cycle while in_stall is low; the mailbox takes one access per cycle and a
// four-word result queue keeps input flowing while the output is stalled, until the queue fills.
// Reset: rx_enable, frame counter and gap timer clear, gap limit resets to 2; mailbox entries read as zero
// through per-entry valid bits, so no clearing pass is needed after reset.
`timescale 1ns / 1ps
`include "serial_can_frame_mailbox_unit_defines.svh"
module serial_can_frame_mailbox_unit #(
	parameter int GAP_COUNT_BITS = scfm_pkg::GAP_COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [scfm_pkg::APB_AW-1:0]       paddr,
	input  logic [scfm_pkg::APB_DW-1:0]       pwdata,
	output logic [scfm_pkg::APB_DW-1:0]       prdata,
	output logic                              pready,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        cmd,
	input  logic [scfm_pkg::BYTE_W-1:0]       rx_byte,
	input  logic [scfm_pkg::ID_W-1:0]         read_id,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic [scfm_pkg::ID_W-1:0]         msg_id,
	output logic [scfm_pkg::LEN_W-1:0]        msg_length,
	output logic [scfm_pkg::BYTE_W-1:0]       data0,
	output logic [scfm_pkg::BYTE_W-1:0]       data1,
	output logic [scfm_pkg::BYTE_W-1:0]       data2,
	output logic [scfm_pkg::BYTE_W-1:0]       data3,
	output logic [scfm_pkg::BYTE_W-1:0]       data4,
	output logic [scfm_pkg::BYTE_W-1:0]       data5,
	output logic [scfm_pkg::BYTE_W-1:0]       data6,
	output logic [scfm_pkg::BYTE_W-1:0]       data7
);

	localparam int OccW = scfm_pkg::Q_CW + 1;

	logic                                rx_enable_q;
	logic [scfm_pkg::GAP_LIMIT_W-1:0]    gap_limit_q;
	logic                                cfg_wr;
	logic                                reg_sel;

	logic                                in_accept;
	logic                                is_read;
	scfm_pkg::frame_evt_t                evt;
	logic                                mb_rd_en;
	logic                                mb_wr_en;
	logic [scfm_pkg::LEN_W-1:0]          mb_len;
	logic [scfm_pkg::DATA_W-1:0]         mb_data;

	logic                                valid_s1;
	logic [1:0]                          status_s1;
	logic [scfm_pkg::ID_W-1:0]           id_s1;
	logic [scfm_pkg::LEN_W-1:0]          len_s1;
	logic [scfm_pkg::DATA_W-1:0]         data_s1;

	scfm_pkg::result_t                   push_data;
	scfm_pkg::result_t                   head;
	logic                                q_pop;
	logic [scfm_pkg::Q_CW-1:0]           q_count;
	logic [OccW-1:0]                     occupancy;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign reg_sel = paddr[scfm_pkg::REG_SEL_BIT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_enable_q <= 1'b0;
			gap_limit_q <= scfm_pkg::GAP_LIMIT_W'(2);
		end else if (cfg_wr) begin
			case (reg_sel)
				scfm_pkg::REG_RX_ENABLE: rx_enable_q <= pwdata[0];
				scfm_pkg::REG_GAP_LIMIT: gap_limit_q <= pwdata[scfm_pkg::GAP_LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			scfm_pkg::REG_RX_ENABLE: prdata = scfm_pkg::APB_DW'(rx_enable_q);
			scfm_pkg::REG_GAP_LIMIT: prdata = scfm_pkg::APB_DW'(gap_limit_q);
			default: prdata = '0;
		endcase
	end

	// Input handshake: stall only on registered occupancy
	assign occupancy = OccW'(q_count) + OccW'(valid_s1);
	assign in_stall = (occupancy >= OccW'(scfm_pkg::Q_DEPTH));
	assign in_accept = in_valid && !in_stall;
	assign is_read = (cmd == scfm_pkg::CMD_READ);

	scfm_frame_asm #(
		.GapCountBits (GAP_COUNT_BITS)
	) u_frame_asm (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.cmd       (cmd),
		.rx_byte   (rx_byte),
		.rx_enable (rx_enable_q),
		.gap_limit (gap_limit_q),
		.evt       (evt)
	);

	// Mailbox: reads and stores come from different words, never the same cycle
	assign mb_rd_en = in_accept && is_read;
	assign mb_wr_en = evt.done && !evt.drop;

	scfm_mailbox u_mailbox (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mb_rd_en),
		.rd_addr (read_id),
		.wr_en   (mb_wr_en),
		.wr_addr (evt.id),
		.wr_len  (evt.len),
		.wr_data (evt.data),
		.rd_len  (mb_len),
		.rd_data (mb_data)
	);

	// Stage 1: result metadata alongside the mailbox read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept && (is_read || evt.done);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			if (is_read) begin
				status_s1 <= scfm_pkg::ST_READ;
				id_s1 <= read_id;
			end else begin
				status_s1 <= evt.drop ? scfm_pkg::ST_DROPPED : scfm_pkg::ST_STORED;
				id_s1 <= evt.id;
			end
			len_s1 <= evt.len;
			data_s1 <= evt.data;
		end
	end

	// Merge read data into the result word
	always_comb begin
		push_data.status = status_s1;
		push_data.id = id_s1;
		if (status_s1 == scfm_pkg::ST_READ) begin
			push_data.len = mb_len;
			push_data.data = mb_data;
		end else begin
			push_data.len = len_s1;
			push_data.data = data_s1;
		end
	end

	assign q_pop = out_valid && !out_stall;

	scfm_result_q u_result_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (push_data),
		.pop       (q_pop),
		.head      (head),
		.not_empty (out_valid),
		.count     (q_count)
	);

	// Output fields
	assign status = head.status;
	assign msg_id = head.id;
	assign msg_length = head.len;
	assign data0 = head.data[0*scfm_pkg::BYTE_W +: scfm_pkg::BYTE_W];
	assign data1 = head.data[1*scfm_pkg::BYTE_W +: scfm_pkg::BYTE_W];
	assign data2 = head.data[2*scfm_pkg::BYTE_W +: scfm_pkg::BYTE_W];
	assign data3 = head.data[3*scfm_pkg::BYTE_W +: scfm_pkg::BYTE_W];
	assign data4 = head.data[4*scfm_pkg::BYTE_W +: scfm_pkg::BYTE_W];
	assign data5 = head.data[5*scfm_pkg::BYTE_W +: scfm_pkg::BYTE_W];
	assign data6 = head.data[6*scfm_pkg::BYTE_W +: scfm_pkg::BYTE_W];
	assign data7 = head.data[7*scfm_pkg::BYTE_W +: scfm_pkg::BYTE_W];

	// Checks
	`SCFM_ASSERT_IMPLIES(a_queue_bound, valid_s1, (q_count < scfm_pkg::Q_CW'(scfm_pkg::Q_DEPTH)), "result queue overrun")
	`SCFM_ASSERT_IMPLIES(a_mb_one_access, mb_wr_en, !mb_rd_en, "mailbox read and store in one cycle")
	`SCFM_ASSERT_NEXT(a_read_lands, mb_rd_en, (valid_s1 && (status_s1 == scfm_pkg::ST_READ)), "read lost in stage 1")

endmodule

/* rtl/scfm_frame_asm.sv */
// Frame assembler: byte counter, gap timer and the ten-byte frame buffer.
`timescale 1ns / 1ps
module scfm_frame_asm #(
	parameter int GapCountBits = scfm_pkg::GAP_COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic [1:0]                           cmd,
	input  logic [scfm_pkg::BYTE_W-1:0]          rx_byte,
	input  logic                                 rx_enable,
	input  logic [scfm_pkg::GAP_LIMIT_W-1:0]     gap_limit,
	output scfm_pkg::frame_evt_t                 evt
);

	localparam int CmpW = (GapCountBits > scfm_pkg::GAP_LIMIT_W) ?
		GapCountBits : scfm_pkg::GAP_LIMIT_W;
	localparam int LenMax = (1 << scfm_pkg::LEN_W) - 1;

	logic [scfm_pkg::BYTE_W-1:0] frame_bytes_q [scfm_pkg::STORED_BYTES];
	logic [scfm_pkg::CNT_W-1:0]  byte_count_q;
	logic [GapCountBits-1:0]     gap_count_q;

	logic                        tick_take;
	logic                        byte_take;
	logic                        restart;
	logic                        done;
	logic [scfm_pkg::CNT_W-1:0]  eff_count;
	logic [scfm_pkg::BYTE_W-1:0] len_byte;

	// Decode the word and the frame position
	always_comb begin
		tick_take = accept && (cmd == scfm_pkg::CMD_TICK);
		byte_take = accept && (cmd == scfm_pkg::CMD_BYTE) && rx_enable;
		restart = CmpW'(gap_count_q) > CmpW'(gap_limit);
		eff_count = restart ? '0 : byte_count_q;
		done = byte_take && (eff_count >= scfm_pkg::CNT_W'(scfm_pkg::STORED_BYTES));
		len_byte = frame_bytes_q[1];
	end

	// Frame fields; checksum byte is never stored
	always_comb begin
		evt.done = done;
		evt.id = frame_bytes_q[0];
		evt.drop = len_byte > scfm_pkg::BYTE_W'(scfm_pkg::MAX_DATA_LEN);
		evt.len = (len_byte > scfm_pkg::BYTE_W'(LenMax)) ?
			scfm_pkg::LEN_W'(LenMax) : len_byte[scfm_pkg::LEN_W-1:0];
		for (int k = 0; k < scfm_pkg::DATA_BYTES; k++) begin
			evt.data[k*scfm_pkg::BYTE_W +: scfm_pkg::BYTE_W] =
				frame_bytes_q[scfm_pkg::FRAME_HDR + k];
		end
	end

	// Counter and saturating gap timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			gap_count_q <= '0;
		end else begin
			if (tick_take && (gap_count_q != '1)) begin
				gap_count_q <= gap_count_q + GapCountBits'(1);
			end else if (byte_take) begin
				gap_count_q <= '0;
			end
			if (byte_take) begin
				byte_count_q <= done ? '0 : eff_count + scfm_pkg::CNT_W'(1);
			end
		end
	end

	// Frame buffer, each byte written at its position
	always_ff @(posedge clk) begin
		for (int k = 0; k < scfm_pkg::STORED_BYTES; k++) begin
			if (byte_take && !done && (eff_count == scfm_pkg::CNT_W'(k))) begin
				frame_bytes_q[k] <= rx_byte;
			end
		end
	end

endmodule

/* rtl/scfm_mailbox.sv */
// Mailbox memory: 256 entries of length and data, registered read, valid bits.
`timescale 1ns / 1ps
module scfm_mailbox (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [scfm_pkg::MB_AW-1:0]    rd_addr,
	input  logic                          wr_en,
	input  logic [scfm_pkg::MB_AW-1:0]    wr_addr,
	input  logic [scfm_pkg::LEN_W-1:0]    wr_len,
	input  logic [scfm_pkg::DATA_W-1:0]   wr_data,
	output logic [scfm_pkg::LEN_W-1:0]    rd_len,
	output logic [scfm_pkg::DATA_W-1:0]   rd_data
);

	localparam int EntryW = scfm_pkg::LEN_W + scfm_pkg::DATA_W;

	logic [EntryW-1:0]            mem [scfm_pkg::MB_DEPTH];
	logic [EntryW-1:0]            rd_q;
	logic                         rd_valid_q;
	logic [scfm_pkg::MB_DEPTH-1:0] valid_q;

	// Storage array, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_len, wr_data};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Per-entry valid bits stand in for clearing the array at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// Never-written entries read as zero
	assign {rd_len, rd_data} = rd_valid_q ? rd_q : '0;

endmodule

/* rtl/scfm_result_q.sv */
// Four-word result queue between the pipeline and the output channel.
`timescale 1ns / 1ps
module scfm_result_q (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  scfm_pkg::result_t           push_data,
	input  logic                        pop,
	output scfm_pkg::result_t           head,
	output logic                        not_empty,
	output logic [scfm_pkg::Q_CW-1:0]   count
);

	scfm_pkg::result_t             entries [scfm_pkg::Q_DEPTH];
	logic [scfm_pkg::Q_AW-1:0]     wr_ptr_q;
	logic [scfm_pkg::Q_AW-1:0]     rd_ptr_q;
	logic [scfm_pkg::Q_CW-1:0]     count_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + scfm_pkg::Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + scfm_pkg::Q_AW'(1);
			end
			count_q <= count_q + scfm_pkg::Q_CW'(push) - scfm_pkg::Q_CW'(pop);
		end
	end

	assign head = entries[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count = count_q;

endmodule

/* dv/tb_top.sv */
// Self-checking testbench of the serial frame mailbox: directed table, random frames, register port.
`timescale 1ns / 1ps
module tb_top;
	import scfm_pkg::*;

	localparam int GAP_BITS = GAP_COUNT_BITS_DEF;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES = 80;

	// Clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Register port
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	// Input channel
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        cmd = CMD_TICK;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic [ID_W-1:0]   read_id = '0;

	// Output channel
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        status;
	logic [ID_W-1:0]   msg_id;
	logic [LEN_W-1:0]  msg_length;
	logic [BYTE_W-1:0] data0, data1, data2, data3, data4, data5, data6, data7;

	serial_can_frame_mailbox_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .rx_byte(rx_byte), .read_id(read_id),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .msg_id(msg_id), .msg_length(msg_length),
		.data0(data0), .data1(data1), .data2(data2), .data3(data3),
		.data4(data4), .data5(data5), .data6(data6), .data7(data7)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Mirror of the block state
	logic [BYTE_W-1:0]      frame_buf [STORED_BYTES];
	logic [CNT_W-1:0]       frame_cnt;
	logic [GAP_BITS-1:0]    silence;
	logic [LEN_W-1:0]       box_len [MB_DEPTH];
	logic [DATA_W-1:0]      box_data [MB_DEPTH];
	logic                   link_on;
	logic [GAP_LIMIT_W-1:0] gap_lim;

	result_t awaited_results[$];

	int mismatch_count = 0;
	int words_sent = 0;
	int results_seen = 0;
	int stored_seen = 0;
	int dropped_seen = 0;
	int reads_seen = 0;

	// Stimulus shaping flags, set by the sender with nonblocking writes
	bit calm = 1'b0;
	bit want_hold = 1'b0;

	// Directed table
	typedef enum logic { ROW_WORD, ROW_CFG } row_kind_t;
	typedef struct packed {
		row_kind_t         kind;
		logic [1:0]        c;
		logic [BYTE_W-1:0] b;
		logic [ID_W-1:0]   rid;
		bit                typed;
		result_t           want;
		logic              reg_idx;
		logic [APB_DW-1:0] val;
	} plan_row_t;

	plan_row_t plan[$];

	function automatic void plan_word(input logic [1:0] c, input logic [BYTE_W-1:0] b,
			input logic [ID_W-1:0] rid);
		plan.push_back('{kind: ROW_WORD, c: c, b: b, rid: rid, typed: 1'b0, want: '0,
			reg_idx: 1'b0, val: '0});
	endfunction

	function automatic void plan_typed(input logic [1:0] c, input logic [BYTE_W-1:0] b,
			input logic [ID_W-1:0] rid, input result_t want);
		plan.push_back('{kind: ROW_WORD, c: c, b: b, rid: rid, typed: 1'b1, want: want,
			reg_idx: 1'b0, val: '0});
	endfunction

	function automatic void plan_cfg(input logic idx, input logic [APB_DW-1:0] val);
		plan.push_back('{kind: ROW_CFG, c: CMD_TICK, b: '0, rid: '0, typed: 1'b0, want: '0,
			reg_idx: idx, val: val});
	endfunction

	// Next result of the block for one accepted word; returns 1 when a result is due
	function automatic bit mailbox_predict(input logic [1:0] c, input logic [BYTE_W-1:0] b,
			input logic [ID_W-1:0] rid, output result_t r);
		logic [DATA_W-1:0] d;
		logic [BYTE_W-1:0] flen;
		r = '0;
		if (c == CMD_TICK) begin
			if (silence != '1)
				silence = silence + 1'b1;
			return 1'b0;
		end
		if (c == CMD_READ) begin
			r.status = ST_READ;
			r.id = rid;
			r.len = box_len[rid];
			r.data = box_data[rid];
			return 1'b1;
		end
		if (c != CMD_BYTE || !link_on)
			return 1'b0;
		// long silence restarts the frame
		if (silence > gap_lim)
			frame_cnt = '0;
		silence = '0;
		if (frame_cnt < STORED_BYTES) begin
			frame_buf[frame_cnt] = b;
			frame_cnt = frame_cnt + 1'b1;
			return 1'b0;
		end
		// checksum byte closes the frame
		d = '0;
		for (int k = 0; k < DATA_BYTES; k++)
			d[8*k +: 8] = frame_buf[FRAME_HDR + k];
		flen = frame_buf[1];
		r.id = frame_buf[0];
		r.data = d;
		if (flen <= MAX_DATA_LEN) begin
			r.status = ST_STORED;
			r.len = flen[LEN_W-1:0];
			box_len[r.id] = flen[LEN_W-1:0];
			box_data[r.id] = d;
		end else begin
			r.status = ST_DROPPED;
			r.len = (flen > 15) ? 4'hF : flen[LEN_W-1:0];
		end
		for (int k = 0; k < STORED_BYTES; k++)
			frame_buf[k] = '0;
		frame_cnt = '0;
		return 1'b1;
	endfunction

	task automatic check_field(input string what, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (want_v !== got_v) begin
			mismatch_count++;
			$display("%0t: %s expected %0h, got %0h", $time, what, want_v, got_v);
		end
	endtask

	// Offer one word, wait for its acceptance, then queue what it should produce
	task automatic send_checked(input logic [1:0] c, input logic [BYTE_W-1:0] b,
			input logic [ID_W-1:0] rid, input bit typed, input result_t want);
		result_t r;
		while (!calm && $urandom_range(0, 99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		rx_byte <= b;
		read_id <= rid;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
		if (mailbox_predict(c, b, rid, r))
			awaited_results.push_back(typed ? want : r);
	endtask

	task automatic send_word(input logic [1:0] c, input logic [BYTE_W-1:0] b,
			input logic [ID_W-1:0] rid);
		send_checked(c, b, rid, 1'b0, '0);
	endtask

	task automatic tick_burst(input int n);
		repeat (n)
			send_word(CMD_TICK, BYTE_W'($urandom_range(0, 255)), ID_W'($urandom_range(0, 255)));
	endtask

	// Let every awaited word come out and the pipeline drain
	task automatic settle();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Register write, then read back through the same port
	task automatic reg_write(input logic idx, input logic [APB_DW-1:0] val);
		logic [APB_DW-1:0] got;
		logic [APB_DW-1:0] mask;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(idx) << REG_SEL_BIT;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == REG_RX_ENABLE) begin
			link_on = val[0];
			mask = 32'h1;
		end else begin
			gap_lim = val[GAP_LIMIT_W-1:0];
			mask = 32'hFFFF;
		end
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		got = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		check_field($sformatf("register %0d readback", idx), 64'(val & mask), 64'(got & mask));
	endtask

	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(0, 1))
			return ID_W'($urandom_range(0, 255));
		return ID_W'($urandom_range(0, 3) * 85);
	endfunction

	// Random words: mostly whole frames with random content, plus reads, ticks and noise
	task automatic random_phase(input int n_words, input bit read_heavy);
		int start;
		int r;
		logic [ID_W-1:0] fid;
		logic [BYTE_W-1:0] flen;
		logic [BYTE_W-1:0] b;
		start = words_sent;
		while (words_sent - start < n_words) begin
			r = $urandom_range(0, 99);
			if (read_heavy && r < 70)
				r = 60;
			if (r < 60) begin
				fid = pick_id();
				flen = ($urandom_range(0, 99) < 85) ? BYTE_W'($urandom_range(0, 8)) :
					BYTE_W'($urandom_range(9, 255));
				for (int k = 0; k < FRAME_LEN; k++) begin
					b = (k == 0) ? fid : (k == 1) ? flen : BYTE_W'($urandom_range(0, 255));
					if (k > 0 && $urandom_range(0, 99) < 8)
						tick_burst($urandom_range(1, 3));
					send_word(CMD_BYTE, b, ID_W'($urandom_range(0, 255)));
				end
			end else if (r < 80) begin
				send_word(CMD_READ, BYTE_W'($urandom_range(0, 255)), pick_id());
			end else if (r < 88) begin
				tick_burst($urandom_range(1, 4));
			end else if (r < 95) begin
				send_word(CMD_BYTE, BYTE_W'($urandom_range(0, 255)),
					ID_W'($urandom_range(0, 255)));
			end else begin
				send_word(2'd3, BYTE_W'($urandom_range(0, 255)), ID_W'($urandom_range(0, 255)));
			end
		end
	endtask

	// Receiver: random stall, plus one long hold-off counted here
	int hold_left = 0;
	bit hold_done = 1'b0;
	always @(posedge clk) begin
		if (want_hold && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(0, 99) < 17);
		end
	end

	// Compare each accepted result word with the oldest awaited one
	always @(posedge clk) begin : result_check
		result_t want;
		logic [DATA_W-1:0] got_data;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (status == ST_STORED)
				stored_seen++;
			else if (status == ST_DROPPED)
				dropped_seen++;
			else
				reads_seen++;
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected none, got status %0h id %0h",
					$time, status, msg_id);
			end else begin
				want = awaited_results.pop_front();
				got_data = {data7, data6, data5, data4, data3, data2, data1, data0};
				check_field("status", 64'(want.status), 64'(status));
				check_field("msg_id", 64'(want.id), 64'(msg_id));
				check_field("msg_length", 64'(want.len), 64'(msg_length));
				for (int k = 0; k < DATA_BYTES; k++)
					check_field($sformatf("data%0d", k), 64'(want.data[8*k +: 8]),
						64'(got_data[8*k +: 8]));
			end
		end
	end

	// Main sequence
	initial begin
		for (int i = 0; i < STORED_BYTES; i++)
			frame_buf[i] = '0;
		for (int i = 0; i < MB_DEPTH; i++) begin
			box_len[i] = '0;
			box_data[i] = '0;
		end
		frame_cnt = '0;
		silence = '0;
		link_on = 1'b0;
		gap_lim = 16'd2;

		// empty mailbox, link off, unused command
		plan_typed(CMD_READ, 8'h00, 8'h00, '{status: ST_READ, id: 8'h00, len: 4'd0, data: '0});
		plan_word(CMD_BYTE, 8'hFF, 8'hFF);
		plan_word(2'd3, 8'hFF, 8'hFF);
		plan_cfg(REG_RX_ENABLE, 32'd1);
		// full-length frame at the top id with all-ones data
		plan_word(CMD_BYTE, 8'hFF, 8'h00);
		plan_word(CMD_BYTE, 8'd8, 8'h00);
		for (int k = 0; k < DATA_BYTES; k++)
			plan_word(CMD_BYTE, 8'hFF, 8'h00);
		plan_typed(CMD_BYTE, 8'h00, 8'h00, '{status: ST_STORED, id: 8'hFF, len: 4'd8, data: '1});
		plan_typed(CMD_READ, 8'h00, 8'hFF, '{status: ST_READ, id: 8'hFF, len: 4'd8, data: '1});
		// stray byte, then silence past the limit, then an oversize frame
		plan_word(CMD_BYTE, 8'h12, 8'h00);
		for (int k = 0; k < 3; k++)
			plan_word(CMD_TICK, 8'h00, 8'h00);
		plan_word(CMD_BYTE, 8'h00, 8'h00);
		plan_word(CMD_BYTE, 8'hFF, 8'h00);
		for (int k = 0; k < DATA_BYTES; k++)
			plan_word(CMD_BYTE, 8'h00, 8'h00);
		plan_typed(CMD_BYTE, 8'hFF, 8'h00, '{status: ST_DROPPED, id: 8'h00, len: 4'hF, data: '0});

		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				settle();
				reg_write(plan[i].reg_idx, plan[i].val);
			end else begin
				send_checked(plan[i].c, plan[i].b, plan[i].rid, plan[i].typed, plan[i].want);
			end
		end

		settle();
		reg_write(REG_GAP_LIMIT, 32'd2);
		random_phase(90, 1'b0);

		settle();
		reg_write(REG_GAP_LIMIT, 32'd0);
		random_phase(80, 1'b0);

		// no idling on either side for this stretch
		settle();
		reg_write(REG_GAP_LIMIT, 32'hFFFF);
		calm <= 1'b1;
		random_phase(80, 1'b0);
		calm <= 1'b0;

		settle();
		reg_write(REG_RX_ENABLE, 32'd0);
		reg_write(REG_GAP_LIMIT, 32'd3);
		random_phase(40, 1'b0);

		// receiver holds off while reads pile up
		settle();
		reg_write(REG_RX_ENABLE, 32'd1);
		reg_write(REG_GAP_LIMIT, $urandom_range(1, 8));
		want_hold <= 1'b1;
		random_phase(100, 1'b1);
		random_phase(60, 1'b0);

		settle();
		reg_write(REG_GAP_LIMIT, 32'd2);
		random_phase(80, 1'b0);

		settle();
		$display("Sent %0d input words; checked %0d results (%0d stored, %0d dropped, %0d reads).",
			words_sent, results_seen, stored_seen, dropped_seen, reads_seen);
		$display("Gap limits 0 to 65535, link on and off, and a long output hold that fills the queue.");
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
